// ===== rtl/idel_pkg.sv =====
// shared types, constants and register codes for the impact detector event log
// no dependencies; imported by the interfaces and every module of the block
`timescale 1ns / 1ps
`default_nettype none

package idel_pkg;

  // fixed field widths
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned ACCEL_W   = 16;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned LEVEL_W   = 2;
  localparam int unsigned DELTA_W   = 16;
  localparam int unsigned BASE_W    = 15;
  localparam int unsigned THR_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 32;
  localparam int unsigned SUM_W     = 32;
  localparam int unsigned ROOT_W    = 16;

  // log depth default, legal range 1 to 64
  localparam int unsigned LOG_DEPTH_DEF = 64;

  // register reset values
  localparam logic [BASE_W-1:0] BASELINE_RST = 15'd4096;
  localparam logic [THR_W-1:0]  IMPACT_RST   = 16'd1434;
  localparam logic [THR_W-1:0]  MEDIUM_RST   = 16'd2867;
  localparam logic [THR_W-1:0]  HIGH_RST     = 16'd4915;
  localparam logic [TIME_W-1:0] COOLDOWN_RST = 32'd500;

  // axis select of the shared squarer
  localparam logic [1:0] AXIS_X    = 2'd0;
  localparam logic [1:0] AXIS_Y    = 2'd1;
  localparam logic [1:0] AXIS_LAST = 2'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_SYNC   = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_IMPACT     = 2'd0,
    KIND_RECORD     = 2'd1,
    KIND_EMPTY      = 2'd2,
    KIND_CLEAR_DONE = 2'd3
  } kind_e;

  typedef enum logic [LEVEL_W-1:0] {
    LVL_LOW    = 2'd0,
    LVL_MEDIUM = 2'd1,
    LVL_HIGH   = 2'd2
  } level_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASELINE = 3'd0,
    REG_IMPACT   = 3'd1,
    REG_MEDIUM   = 3'd2,
    REG_HIGH     = 3'd3,
    REG_COOLDOWN = 3'd4
  } cfg_reg_e;

  // one stored impact
  typedef struct packed {
    logic [TIME_W-1:0]  ev_time;
    logic [DELTA_W-1:0] delta;
    level_e             level;
  } log_entry_t;

  // one result item
  typedef struct packed {
    kind_e              kind;
    logic [IDX_W-1:0]   entry_index;
    logic [LEVEL_W-1:0] level;
    logic [DELTA_W-1:0] delta;
    logic [TIME_W-1:0]  event_time;
    logic               last;
  } out_item_t;

  // root unit handshake
  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_status_t;

endpackage

`default_nettype wire

// ===== rtl/idel_if.sv =====
// valid/ready channel interfaces: sample/command input, result output, register writes
// depends on idel_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface idel_in_if;
  logic                                valid;
  logic                                ready;
  logic [idel_pkg::CMD_W-1:0]          command;
  logic signed [idel_pkg::ACCEL_W-1:0] accel_x;
  logic signed [idel_pkg::ACCEL_W-1:0] accel_y;
  logic signed [idel_pkg::ACCEL_W-1:0] accel_z;
  logic [idel_pkg::TIME_W-1:0]         timestamp_ms;

  modport source (output valid, command, accel_x, accel_y, accel_z, timestamp_ms,
                  input ready);
  modport sink (input valid, command, accel_x, accel_y, accel_z, timestamp_ms,
                output ready);
endinterface

interface idel_out_if;
  logic                         valid;
  logic                         ready;
  logic [idel_pkg::KIND_W-1:0]  kind;
  logic [idel_pkg::IDX_W-1:0]   entry_index;
  logic [idel_pkg::LEVEL_W-1:0] level;
  logic [idel_pkg::DELTA_W-1:0] delta;
  logic [idel_pkg::TIME_W-1:0]  event_time;
  logic                         last;

  modport source (output valid, kind, entry_index, level, delta, event_time, last,
                  input ready);
  modport sink (input valid, kind, entry_index, level, delta, event_time, last,
                output ready);
endinterface

interface idel_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [idel_pkg::CFG_IDX_W-1:0] reg_idx;
  logic [idel_pkg::CFG_DAT_W-1:0] wdata;

  modport source (output valid, reg_idx, wdata, input ready);
  modport sink (input valid, reg_idx, wdata, output ready);
endinterface

`default_nettype wire

// ===== rtl/idel_isqrt.sv =====
// iterative floor square root of a 32-bit value, one root bit per iteration step
// depends on idel_pkg for widths and the status struct
`timescale 1ns / 1ps
`default_nettype none

module idel_isqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [idel_pkg::SUM_W-1:0]   radicand_i,
  output idel_pkg::sqrt_status_t       status_o,
  output logic [idel_pkg::ROOT_W-1:0]  root_o
);
  import idel_pkg::*;

  localparam logic [SUM_W-1:0] BIT_TOP = SUM_W'(1) << (SUM_W - 2);

  logic [SUM_W-1:0] rem_q, rem_d;
  logic [SUM_W-1:0] root_q, root_d;
  logic [SUM_W-1:0] bit_q, bit_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [SUM_W-1:0] trial;

  assign trial = root_q + bit_q;

  always_comb begin
    rem_d  = rem_q;
    root_d = root_q;
    bit_d  = bit_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = radicand_i;
      root_d = '0;
      bit_d  = BIT_TOP;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_q >= trial) begin
        rem_d  = rem_q - trial;
        root_d = (root_q >> 1) + bit_q;
      end else begin
        root_d = root_q >> 1;
      end
      bit_d = bit_q >> 2;
      // final step when the trial bit reaches the lsb
      if (bit_q == SUM_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    root_q <= root_d;
    bit_q  <= bit_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign root_o        = root_q[ROOT_W-1:0];

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("root unit started while busy");

  a_root_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (root_q[SUM_W-1:ROOT_W] == '0))
    else $error("square root result exceeds 16 bits");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ($past(busy_q) && !busy_q))
    else $error("root done without a finished iteration");

endmodule

`default_nettype wire

// ===== rtl/idel_log_mem.sv =====
// event log storage: one write port, one read port, registered read data
// depends on idel_pkg for the entry type
`timescale 1ns / 1ps
`default_nettype none

module idel_log_mem #(
  parameter int unsigned DEPTH = idel_pkg::LOG_DEPTH_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AW-1:0]         waddr_i,
  input  idel_pkg::log_entry_t  wdata_i,
  input  logic                  re_i,
  input  logic [AW-1:0]         raddr_i,
  output idel_pkg::log_entry_t  rdata_o
);
  import idel_pkg::*;

  log_entry_t mem [DEPTH];
  log_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/impact_detector_event_log_core.sv =====
// impact detector with event log: top level, command sequencer and registers
// depends on idel_pkg, idel_if, idel_isqrt and idel_log_mem
`timescale 1ns / 1ps
`default_nettype none

// channel | dir | carries                                        | request taken when
// in_i    | in  | command, accel_x/y/z, timestamp_ms              | valid & ready
// out_o   | out | kind, entry_index, level, delta, event_time, last | valid & ready
// cfg_i   | in  | reg_idx, wdata                                  | valid & ready
//
// a sample request runs from its accept through the shared squarer, one axis at a time,
// then the 16-step root unit (start, 16 steps, done), then delta and the qualify check
// with the log write
// a sync request emits its records one at a time, each read from the log read port first
// clear and empty-sync requests finish in the reply state; one request is in work at a time
// reset clears control, count and cooldown time; the log itself is left as is
// a stalled output holds the sequencer at its next result, nothing is dropped

module impact_detector_event_log_core #(
  parameter int unsigned LOG_DEPTH = idel_pkg::LOG_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  idel_in_if.sink   in_i,
  idel_out_if.source out_o,
  idel_cfg_if.sink  cfg_i
);
  import idel_pkg::*;

  localparam int unsigned AW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int unsigned CW = $clog2(LOG_DEPTH + 1);

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_SQUARE   = 8'b0000_0010,
    ST_ROOT     = 8'b0000_0100,
    ST_DELTA    = 8'b0000_1000,
    ST_DECIDE   = 8'b0001_0000,
    ST_REPLY    = 8'b0010_0000,
    ST_DUMP_RD  = 8'b0100_0000,
    ST_DUMP_OUT = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [BASE_W-1:0] baseline_q;
  logic [THR_W-1:0]  impact_thr_q;
  logic [THR_W-1:0]  medium_thr_q;
  logic [THR_W-1:0]  high_thr_q;
  logic [TIME_W-1:0] cooldown_q;

  // sample working registers
  logic [ACCEL_W-1:0] abs_x_q, abs_x_d;
  logic [ACCEL_W-1:0] abs_y_q, abs_y_d;
  logic [ACCEL_W-1:0] abs_z_q, abs_z_d;
  logic [TIME_W-1:0]  ts_q, ts_d;
  logic [1:0]         sel_q, sel_d;
  logic [SUM_W-1:0]   acc_q, acc_d;
  logic               sqrt_start_q, sqrt_start_d;
  logic [ROOT_W-1:0]  mag_q, mag_d;
  logic [DELTA_W-1:0] delta_q, delta_d;
  logic [TIME_W-1:0]  elapsed_q, elapsed_d;

  // log bookkeeping
  logic [CW-1:0]      count_q, count_d;
  logic [TIME_W-1:0]  last_time_q, last_time_d;
  logic [CW-1:0]      dump_idx_q, dump_idx_d;
  kind_e              reply_kind_q, reply_kind_d;

  // output register
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q, out_d;
  logic               out_load;
  logic               slot_free;

  logic               in_acc;
  logic [ACCEL_W-1:0] sq_op;
  logic [SUM_W-1:0]   sq_prod;
  logic               full;
  logic               qualify;
  level_e             lvl;
  logic [IDX_W-1:0]   impact_idx;
  logic               dump_last;

  sqrt_status_t       sqrt_st;
  logic [ROOT_W-1:0]  sqrt_root;

  logic               mem_we;
  logic               mem_re;
  log_entry_t         mem_wdata;
  log_entry_t         mem_rdata;

  function automatic logic [ACCEL_W-1:0] abs_val(input logic [ACCEL_W-1:0] v);
    return v[ACCEL_W-1] ? (~v + ACCEL_W'(1)) : v;
  endfunction

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign slot_free   = !out_valid_q || out_o.ready;
  assign cfg_i.ready = 1'b1;

  // one squarer shared by the three axes
  always_comb begin
    case (sel_q)
      AXIS_X:  sq_op = abs_x_q;
      AXIS_Y:  sq_op = abs_y_q;
      default: sq_op = abs_z_q;
    endcase
  end
  assign sq_prod = SUM_W'(sq_op) * SUM_W'(sq_op);

  assign full       = (count_q == CW'(LOG_DEPTH));
  assign qualify    = (delta_q >= impact_thr_q) && (elapsed_q >= cooldown_q);
  assign impact_idx = full ? IDX_W'(LOG_DEPTH - 1) : IDX_W'(count_q);
  assign dump_last  = ((dump_idx_q + CW'(1)) == count_q);

  always_comb begin
    if (delta_q >= high_thr_q) begin
      lvl = LVL_HIGH;
    end else if (delta_q >= medium_thr_q) begin
      lvl = LVL_MEDIUM;
    end else begin
      lvl = LVL_LOW;
    end
  end

  assign mem_wdata.ev_time = ts_q;
  assign mem_wdata.delta   = delta_q;
  assign mem_wdata.level   = lvl;

  // sequencer
  always_comb begin
    state_d      = state_q;
    abs_x_d      = abs_x_q;
    abs_y_d      = abs_y_q;
    abs_z_d      = abs_z_q;
    ts_d         = ts_q;
    sel_d        = sel_q;
    acc_d        = acc_q;
    sqrt_start_d = 1'b0;
    mag_d        = mag_q;
    delta_d      = delta_q;
    elapsed_d    = elapsed_q;
    count_d      = count_q;
    last_time_d  = last_time_q;
    dump_idx_d   = dump_idx_q;
    reply_kind_d = reply_kind_q;
    out_d        = out_q;
    out_load     = 1'b0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_i.command)
            CMD_SAMPLE: begin
              abs_x_d = abs_val(in_i.accel_x);
              abs_y_d = abs_val(in_i.accel_y);
              abs_z_d = abs_val(in_i.accel_z);
              ts_d    = in_i.timestamp_ms;
              sel_d   = AXIS_X;
              acc_d   = '0;
              state_d = ST_SQUARE;
            end
            CMD_SYNC: begin
              if (count_q == '0) begin
                reply_kind_d = KIND_EMPTY;
                state_d      = ST_REPLY;
              end else begin
                dump_idx_d = '0;
                state_d    = ST_DUMP_RD;
              end
            end
            CMD_CLEAR: begin
              reply_kind_d = KIND_CLEAR_DONE;
              state_d      = ST_REPLY;
            end
            default: begin
              // unused command code, dropped without a result
              state_d = ST_IDLE;
            end
          endcase
        end
      end

      ST_SQUARE: begin
        acc_d = acc_q + sq_prod;
        sel_d = sel_q + 2'd1;
        if (sel_q == AXIS_LAST) begin
          sqrt_start_d = 1'b1;
          state_d      = ST_ROOT;
        end
      end

      ST_ROOT: begin
        if (sqrt_st.done) begin
          mag_d   = sqrt_root;
          state_d = ST_DELTA;
        end
      end

      ST_DELTA: begin
        // magnitude may sit on either side of the baseline
        if (mag_q >= ROOT_W'(baseline_q)) begin
          delta_d = mag_q - ROOT_W'(baseline_q);
        end else begin
          delta_d = ROOT_W'(baseline_q) - mag_q;
        end
        elapsed_d = ts_q - last_time_q;
        state_d   = ST_DECIDE;
      end

      ST_DECIDE: begin
        if (!qualify) begin
          state_d = ST_IDLE;
        end else if (slot_free) begin
          // a full log still reports and still restarts the cooldown
          last_time_d = ts_q;
          if (!full) begin
            mem_we  = 1'b1;
            count_d = count_q + CW'(1);
          end
          out_load          = 1'b1;
          out_d.kind        = KIND_IMPACT;
          out_d.entry_index = impact_idx;
          out_d.level       = lvl;
          out_d.delta       = delta_q;
          out_d.event_time  = ts_q;
          out_d.last        = 1'b1;
          state_d           = ST_IDLE;
        end
      end

      ST_REPLY: begin
        if (slot_free) begin
          if (reply_kind_q == KIND_CLEAR_DONE) begin
            // entries stay in memory, only the fill count drops
            count_d = '0;
          end
          out_load          = 1'b1;
          out_d.kind        = reply_kind_q;
          out_d.entry_index = '0;
          out_d.level       = '0;
          out_d.delta       = '0;
          out_d.event_time  = '0;
          out_d.last        = 1'b1;
          state_d           = ST_IDLE;
        end
      end

      ST_DUMP_RD: begin
        mem_re  = 1'b1;
        state_d = ST_DUMP_OUT;
      end

      ST_DUMP_OUT: begin
        if (slot_free) begin
          out_load          = 1'b1;
          out_d.kind        = KIND_RECORD;
          out_d.entry_index = IDX_W'(dump_idx_q);
          out_d.level       = mem_rdata.level;
          out_d.delta       = mem_rdata.delta;
          out_d.event_time  = mem_rdata.ev_time;
          out_d.last        = dump_last;
          if (dump_last) begin
            state_d = ST_IDLE;
          end else begin
            dump_idx_d = dump_idx_q + CW'(1);
            state_d    = ST_DUMP_RD;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      last_time_q  <= '0;
      out_valid_q  <= 1'b0;
      sqrt_start_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      last_time_q  <= last_time_d;
      out_valid_q  <= out_valid_d;
      sqrt_start_q <= sqrt_start_d;
    end
  end

  // payload and working registers
  always_ff @(posedge clk_i) begin
    abs_x_q      <= abs_x_d;
    abs_y_q      <= abs_y_d;
    abs_z_q      <= abs_z_d;
    ts_q         <= ts_d;
    sel_q        <= sel_d;
    acc_q        <= acc_d;
    mag_q        <= mag_d;
    delta_q      <= delta_d;
    elapsed_q    <= elapsed_d;
    dump_idx_q   <= dump_idx_d;
    reply_kind_q <= reply_kind_d;
    out_q        <= out_d;
  end

  // register writes, indexes beyond the list are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      baseline_q   <= BASELINE_RST;
      impact_thr_q <= IMPACT_RST;
      medium_thr_q <= MEDIUM_RST;
      high_thr_q   <= HIGH_RST;
      cooldown_q   <= COOLDOWN_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.reg_idx)
        REG_BASELINE: baseline_q   <= cfg_i.wdata[BASE_W-1:0];
        REG_IMPACT:   impact_thr_q <= cfg_i.wdata[THR_W-1:0];
        REG_MEDIUM:   medium_thr_q <= cfg_i.wdata[THR_W-1:0];
        REG_HIGH:     high_thr_q   <= cfg_i.wdata[THR_W-1:0];
        REG_COOLDOWN: cooldown_q   <= cfg_i.wdata[TIME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.kind        = out_q.kind;
  assign out_o.entry_index = out_q.entry_index;
  assign out_o.level       = out_q.level;
  assign out_o.delta       = out_q.delta;
  assign out_o.event_time  = out_q.event_time;
  assign out_o.last        = out_q.last;

  idel_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start_q),
    .radicand_i (acc_q),
    .status_o   (sqrt_st),
    .root_o     (sqrt_root)
  );

  // write and read never overlap: the sequencer handles one request at a time
  idel_log_mem #(
    .DEPTH (LOG_DEPTH),
    .AW    (AW)
  ) u_log_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (dump_idx_q[AW-1:0]),
    .rdata_o (mem_rdata)
  );

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(LOG_DEPTH))
    else $error("log fill count beyond depth");

  a_write_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (!full && !mem_re))
    else $error("log write while full or during a read");

  a_root_in_root_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_st.done |-> (state_q == ST_ROOT))
    else $error("root result arrived outside the root wait");

  a_dump_ends_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DUMP_OUT && out_load && dump_last) |=> (state_q == ST_IDLE))
    else $error("sync dump did not return to idle after its last record");

  a_dump_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DUMP_RD) |-> (dump_idx_q < count_q))
    else $error("sync dump read past the fill count");

endmodule

`default_nettype wire
